// File: hw/rtl/piecewise_linear_interpolator_unit_macros.svh
// Assertion helpers for the interpolator; define NO_ASSERTIONS to drop them.
`ifndef PIECEWISE_LINEAR_INTERPOLATOR_UNIT_MACROS_SVH
`define PIECEWISE_LINEAR_INTERPOLATOR_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication
`define PLI_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("interpolator assertion failed");

// Next-cycle implication
`define PLI_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("interpolator assertion failed");

// Invariant
`define PLI_ASSERT_ALWAYS(name, clk, rst_n, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("interpolator assertion failed");

`else

`define PLI_ASSERT_IMPL(name, clk, rst_n, ante, cons)
`define PLI_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`define PLI_ASSERT_ALWAYS(name, clk, rst_n, cond)

`endif

`endif

// File: hw/rtl/pli_pkg.sv
package pli_pkg;

    // Table geometry and value format
    localparam int MAX_POINTS  = 64;
    localparam int VALUE_WIDTH = 32;
    localparam int IDX_W       = $clog2(MAX_POINTS);
    localparam int CNT_W       = $clog2(MAX_POINTS + 1);

    // Configuration port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    typedef enum logic [APB_AW-3:0] {
        REG_POINT_COUNT = 1'b0
    } t_reg_idx;

    typedef enum logic {
        OP_LOAD   = 1'b0,
        OP_SAMPLE = 1'b1
    } t_op;

    // Sample sequencer
    typedef enum logic [3:0] {
        S_IDLE,
        S_RD0,
        S_RDL,
        S_CHK,
        S_SRCH,
        S_SCMP,
        S_DIFF,
        S_MUL,
        S_DIVGO,
        S_DIV,
        S_SUM,
        S_DONE
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

    // Magnitude of a signed difference; -2^VALUE_WIDTH still fits unsigned
    function automatic logic [VALUE_WIDTH:0] pli_mag(input logic [VALUE_WIDTH:0] v);
        logic [VALUE_WIDTH:0] r;
        r = v[VALUE_WIDTH] ? (~v + 1'b1) : v;
        return r;
    endfunction

endpackage

// File: hw/rtl/pli_in_if.sv
interface pli_in_if;
    logic                                     valid;
    logic                                     ready;
    pli_pkg::t_op                             operation;
    logic        [pli_pkg::IDX_W-1:0]         point_index;
    logic signed [pli_pkg::VALUE_WIDTH-1:0]   point_x;
    logic signed [pli_pkg::VALUE_WIDTH-1:0]   point_y;
    logic signed [pli_pkg::VALUE_WIDTH-1:0]   query_x;

    modport source (
        output valid, operation, point_index, point_x, point_y, query_x,
        input  ready
    );
    modport sink (
        input  valid, operation, point_index, point_x, point_y, query_x,
        output ready
    );
endinterface

// File: hw/rtl/pli_out_if.sv
interface pli_out_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [pli_pkg::VALUE_WIDTH-1:0]   result_y;

    modport source (
        output valid, result_y,
        input  ready
    );
    modport sink (
        input  valid, result_y,
        output ready
    );
endinterface

// File: hw/rtl/pli_ram.sv
module pli_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/pli_div_unit.sv
module pli_div_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [2*pli_pkg::VALUE_WIDTH+1:0] i_dividend,
    input  logic [pli_pkg::VALUE_WIDTH:0]     i_divisor,
    output pli_pkg::t_div_status              o_status,
    output logic [pli_pkg::VALUE_WIDTH:0]     o_quotient
);

    localparam int VW = pli_pkg::VALUE_WIDTH;
    localparam int CW = $clog2(VW + 1);

    logic          r_busy, n_busy;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [VW:0]   r_rem, n_rem;
    logic [VW-1:0] r_low, n_low;
    logic [VW:0]   r_den, n_den;
    logic          r_sat, n_sat;

    logic          ovf;
    logic [VW+1:0] trial;
    logic [VW+1:0] diff;
    logic          ge;

    // quotient of 2^VW or more saturates: high half already >= divisor
    assign ovf   = i_dividend[2*VW+1:VW] >= {1'b0, i_divisor};

    // one restoring step a cycle; quotient bits shift into the low word
    assign trial = {r_rem, r_low[VW-1]};
    assign diff  = trial - {1'b0, r_den};
    assign ge    = trial >= {1'b0, r_den};

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_low  = r_low;
        n_den  = r_den;
        n_sat  = r_sat;
        priority if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = ovf ? CW'(1) : CW'(VW);
            n_rem  = i_dividend[2*VW:VW];
            n_low  = i_dividend[VW-1:0];
            n_den  = i_divisor;
            n_sat  = ovf;
        end else if (r_busy) begin
            n_rem  = ge ? diff[VW:0] : trial[VW:0];
            n_low  = {r_low[VW-2:0], ge};
            n_cnt  = r_cnt - 1'b1;
            n_busy = (r_cnt != CW'(1));
        end else begin
            // idle: everything holds
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_low <= n_low;
        r_den <= n_den;
        r_sat <= n_sat;
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_busy && (r_cnt == CW'(1));
    assign o_quotient    = r_sat ? {1'b1, {VW{1'b0}}} : {1'b0, r_low};

endmodule

// File: hw/rtl/piecewise_linear_interpolator_unit.sv
// Piecewise linear interpolator over a table of up to 64 Q16.16 breakpoints.
// Input channel i_in: a load word (operation = load) writes x and y into
// slot point_index and gives no result. A sample word gives one
// result_y on o_out: the first/last y outside the table, else the line
// through the bracketing pair, saturated to 32 bits.
// Register point_count (byte address 0) picks the slots in use, clamped to
// 2..64; write it only while the block is idle.
// A sample holds the block busy; i_in.ready is high only when idle. A query
// outside the table skips the search and the divider; else up to 6 binary
// search steps (one table read and one compare each, through the single
// read port of the table RAM) find the bracket, then the one-bit-per-cycle
// divider runs. Equal bracketing x values skip the divider; a quotient too
// large to fit stops the divider after a single step and saturates. The
// next word is taken in the cycle after the result loads.
// The result sits in an output register, so a stalled receiver does not
// stop the next word from being taken; a finished result waits only while
// the output register is still full.
// Reset (synchronous, active low) clears the sequencer, the output valid and
// sets point_count to 2. Table contents are not cleared: load a slot before
// a sample reads it.
module piecewise_linear_interpolator_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    pli_in_if.sink                      i_in,
    pli_out_if.source                   o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pli_pkg::APB_AW-1:0]  paddr,
    input  logic [pli_pkg::APB_DW-1:0]  pwdata,
    output logic [pli_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);

    `include "piecewise_linear_interpolator_unit_macros.svh"

    localparam int VW    = pli_pkg::VALUE_WIDTH;
    localparam int IDX_W = pli_pkg::IDX_W;
    localparam int CNT_W = pli_pkg::CNT_W;

    pli_pkg::t_state r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;

    logic signed [VW-1:0] r_q, n_q;
    logic signed [VW-1:0] r_xl, n_xl;
    logic signed [VW-1:0] r_yl, n_yl;
    logic signed [VW-1:0] r_xh, n_xh;
    logic signed [VW-1:0] r_yh, n_yh;
    logic [IDX_W-1:0]     r_lo, n_lo;
    logic [IDX_W-1:0]     r_hi, n_hi;
    logic [VW:0]          r_dx, n_dx;
    logic [VW:0]          r_dy, n_dy;
    logic [VW:0]          r_dxi, n_dxi;
    logic [2*VW+1:0]      r_prod, n_prod;
    logic [VW:0]          r_den, n_den;
    logic                 r_neg, n_neg;
    logic [VW-1:0]        r_res, n_res;
    logic                 r_ovalid, n_ovalid;
    logic [VW-1:0]        r_oy, n_oy;

    logic                 in_acc;
    logic                 ld_we;
    logic                 cfg_we;
    logic [CNT_W-1:0]     cfg_val;
    logic [CNT_W-1:0]     cnt_m1;
    logic [IDX_W-1:0]     last_idx;
    logic [IDX_W:0]       mid_sum;
    logic [IDX_W-1:0]     mid;
    logic [IDX_W-1:0]     raddr;
    logic [2*VW-1:0]      rdata;
    logic signed [VW-1:0] rd_x;
    logic signed [VW-1:0] rd_y;
    logic                 out_load;
    logic [IDX_W-1:0]     step_lo;
    logic [IDX_W-1:0]     step_hi;
    logic                 q_below;
    logic [VW+1:0]        yl_ext;
    logic [VW+1:0]        quo_ext;
    logic [VW+1:0]        sum;
    logic [VW:0]          quo;
    pli_pkg::t_div_status div_st;

    // handshakes
    assign i_in.ready = (r_state == pli_pkg::S_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;
    assign ld_we      = in_acc && (i_in.operation == pli_pkg::OP_LOAD);

    // configuration port
    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite && pready &&
                     (paddr[pli_pkg::APB_AW-1:2] == pli_pkg::REG_POINT_COUNT);
    assign cfg_val = pwdata[CNT_W-1:0];
    assign prdata  = (paddr[pli_pkg::APB_AW-1:2] == pli_pkg::REG_POINT_COUNT) ?
                     pli_pkg::APB_DW'(r_count) : '0;

    always_comb begin
        n_count = r_count;
        if (cfg_we) begin
            priority if (cfg_val < CNT_W'(2)) begin
                n_count = CNT_W'(2);
            end else if (cfg_val > CNT_W'(pli_pkg::MAX_POINTS)) begin
                n_count = CNT_W'(pli_pkg::MAX_POINTS);
            end else begin
                n_count = cfg_val;
            end
        end
    end

    // table read address: first slot, last slot in use, or search midpoint
    assign cnt_m1   = r_count - 1'b1;
    assign last_idx = cnt_m1[IDX_W-1:0];
    assign mid_sum  = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid      = mid_sum[IDX_W:1];

    always_comb begin
        unique case (r_state)
            pli_pkg::S_RD0: raddr = '0;
            pli_pkg::S_RDL: raddr = last_idx;
            default:        raddr = mid;
        endcase
    end

    pli_ram #(
        .WIDTH (2 * VW),
        .DEPTH (pli_pkg::MAX_POINTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ld_we),
        .i_waddr (i_in.point_index),
        .i_wdata ({i_in.point_x, i_in.point_y}),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign rd_x = rdata[2*VW-1:VW];
    assign rd_y = rdata[VW-1:0];

    pli_div_unit u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == pli_pkg::S_DIVGO),
        .i_dividend (r_prod),
        .i_divisor  (r_den),
        .o_status   (div_st),
        .o_quotient (quo)
    );

    // search step: narrow the bracket around the query
    assign q_below = r_q < rd_x;
    assign step_lo = q_below ? r_lo : mid;
    assign step_hi = q_below ? mid : r_hi;

    // final add, y[lo] +/- quotient
    assign yl_ext  = {{2{r_yl[VW-1]}}, r_yl};
    assign quo_ext = {1'b0, quo};
    assign sum     = r_neg ? (yl_ext - quo_ext) : (yl_ext + quo_ext);

    assign out_load = (r_state == pli_pkg::S_DONE) && (!r_ovalid || o_out.ready);

    // sequencer
    always_comb begin
        n_state = r_state;
        n_q     = r_q;
        n_xl    = r_xl;
        n_yl    = r_yl;
        n_xh    = r_xh;
        n_yh    = r_yh;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_dx    = r_dx;
        n_dy    = r_dy;
        n_dxi   = r_dxi;
        n_prod  = r_prod;
        n_den   = r_den;
        n_neg   = r_neg;
        n_res   = r_res;
        unique case (r_state)
            pli_pkg::S_IDLE: begin
                if (in_acc && (i_in.operation == pli_pkg::OP_SAMPLE)) begin
                    n_q     = i_in.query_x;
                    n_state = pli_pkg::S_RD0;
                end
            end
            pli_pkg::S_RD0: begin
                n_state = pli_pkg::S_RDL;
            end
            pli_pkg::S_RDL: begin
                n_xl    = rd_x;
                n_yl    = rd_y;
                n_state = pli_pkg::S_CHK;
            end
            pli_pkg::S_CHK: begin
                n_xh = rd_x;
                n_yh = rd_y;
                n_lo = '0;
                n_hi = last_idx;
                priority if (r_q < r_xl) begin
                    n_res   = r_yl;
                    n_state = pli_pkg::S_DONE;
                end else if (r_q > rd_x) begin
                    n_res   = rd_y;
                    n_state = pli_pkg::S_DONE;
                end else if ((CNT_W'(1) + CNT_W'(1)) < r_count) begin
                    n_state = pli_pkg::S_SRCH;
                end else begin
                    n_state = pli_pkg::S_DIFF;
                end
            end
            pli_pkg::S_SRCH: begin
                n_state = pli_pkg::S_SCMP;
            end
            pli_pkg::S_SCMP: begin
                n_lo = step_lo;
                n_hi = step_hi;
                if (q_below) begin
                    n_xh = rd_x;
                    n_yh = rd_y;
                end else begin
                    n_xl = rd_x;
                    n_yl = rd_y;
                end
                if (({1'b0, step_lo} + 1'b1) < {1'b0, step_hi}) begin
                    n_state = pli_pkg::S_SRCH;
                end else begin
                    n_state = pli_pkg::S_DIFF;
                end
            end
            pli_pkg::S_DIFF: begin
                n_dx    = {r_q[VW-1], r_q} - {r_xl[VW-1], r_xl};
                n_dy    = {r_yh[VW-1], r_yh} - {r_yl[VW-1], r_yl};
                n_dxi   = {r_xh[VW-1], r_xh} - {r_xl[VW-1], r_xl};
                n_state = pli_pkg::S_MUL;
            end
            pli_pkg::S_MUL: begin
                n_prod = pli_pkg::pli_mag(r_dx) * pli_pkg::pli_mag(r_dy);
                n_den  = pli_pkg::pli_mag(r_dxi);
                n_neg  = (r_dx[VW] ^ r_dy[VW]) ^ r_dxi[VW];
                if (r_dxi == '0) begin
                    n_res   = r_yl;
                    n_state = pli_pkg::S_DONE;
                end else begin
                    n_state = pli_pkg::S_DIVGO;
                end
            end
            pli_pkg::S_DIVGO: begin
                n_state = pli_pkg::S_DIV;
            end
            pli_pkg::S_DIV: begin
                if (div_st.done) begin
                    n_state = pli_pkg::S_SUM;
                end
            end
            pli_pkg::S_SUM: begin
                // saturate to the signed value range
                priority if (!sum[VW+1] && (sum[VW:VW-1] != 2'b00)) begin
                    n_res = {1'b0, {(VW-1){1'b1}}};
                end else if (sum[VW+1] && (sum[VW:VW-1] != 2'b11)) begin
                    n_res = {1'b1, {(VW-1){1'b0}}};
                end else begin
                    n_res = sum[VW-1:0];
                end
                n_state = pli_pkg::S_DONE;
            end
            pli_pkg::S_DONE: begin
                if (out_load) begin
                    n_state = pli_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pli_pkg::S_IDLE;
            end
        endcase
    end

    // output register
    always_comb begin
        n_ovalid = r_ovalid;
        n_oy     = r_oy;
        priority if (out_load) begin
            n_ovalid = 1'b1;
            n_oy     = r_res;
        end else if (o_out.ready) begin
            n_ovalid = 1'b0;
        end else begin
            // receiver stalled: word holds
        end
    end

    assign o_out.valid    = r_ovalid;
    assign o_out.result_y = r_oy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= pli_pkg::S_IDLE;
            r_count  <= CNT_W'(2);
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q    <= n_q;
        r_xl   <= n_xl;
        r_yl   <= n_yl;
        r_xh   <= n_xh;
        r_yh   <= n_yh;
        r_lo   <= n_lo;
        r_hi   <= n_hi;
        r_dx   <= n_dx;
        r_dy   <= n_dy;
        r_dxi  <= n_dxi;
        r_prod <= n_prod;
        r_den  <= n_den;
        r_neg  <= n_neg;
        r_res  <= n_res;
        r_oy   <= n_oy;
    end

    // checks
    `PLI_ASSERT_ALWAYS(a_count_range, i_clk, i_rst_n,
        (r_count >= CNT_W'(2)) && (r_count <= CNT_W'(pli_pkg::MAX_POINTS)))
    `PLI_ASSERT_IMPL(a_bracket_order, i_clk, i_rst_n,
        r_state == pli_pkg::S_SCMP, r_lo < r_hi)
    `PLI_ASSERT_IMPL(a_div_running, i_clk, i_rst_n,
        r_state == pli_pkg::S_DIV, div_st.busy)
    `PLI_ASSERT_NEXT(a_load_silent, i_clk, i_rst_n,
        ld_we && !o_out.valid, !o_out.valid)

endmodule
